### rtl/core/mebf_pkg.sv
// Shared types, codes and constants for the mono expand / blit and fill unit.
// No dependencies; every other file in rtl/core except mebf_ifs.sv imports this package.
package mebf_pkg;

  // Request command codes
  typedef enum logic {
    CMD_BEGIN = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  // Framebuffer depth codes; the code also gives log2 of bytes per pixel
  typedef enum logic [1:0] {
    DEPTH_8    = 2'd0,
    DEPTH_16   = 2'd1,
    DEPTH_32   = 2'd2,
    DEPTH_NONE = 2'd3
  } depth_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FRAME_BASE    = 2'd0,
    REG_SCREEN_WIDTH  = 2'd1,
    REG_SCREEN_HEIGHT = 2'd2,
    REG_DEPTH_MODE    = 2'd3
  } reg_idx_t;

  localparam int          APB_ADDR_W         = 4;
  localparam logic [11:0] RST_SCREEN_WIDTH   = 12'd640;
  localparam logic [11:0] RST_SCREEN_HEIGHT  = 12'd480;
  localparam logic [31:0] GLYPH_BACKGROUND   = 32'h00ff_e52d;

  // Configuration seen by the pixel stage
  typedef struct packed {
    logic [31:0] frame_base;
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    depth_t      depth_mode;
  } cfg_t;

  // One pixel position handed from the walker to the pixel stage
  typedef struct packed {
    logic signed [13:0] x;
    logic signed [13:0] y;
    logic [31:0]        colour;
    logic               glyph;
    logic [7:0]         coverage;
    logic               last;
  } walk_t;

  // Pack a 0xRRGGBB colour into RGB565
  function automatic logic [15:0] to_rgb565(input logic [31:0] c);
    to_rgb565 = {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

### rtl/core/mebf_ifs.sv
// Valid/ready channel interfaces for pixel requests and framebuffer writes.
// No dependencies.
interface mebf_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [11:0] left;
  logic signed [11:0] top;
  logic [11:0]        region_width;
  logic [11:0]        region_height;
  logic               fill_mode;
  logic [31:0]        colour;
  logic [7:0]         coverage;

  modport source (output valid, command, left, top, region_width, region_height,
                  fill_mode, colour, coverage, input ready);
  modport sink   (input valid, command, left, top, region_width, region_height,
                  fill_mode, colour, coverage, output ready);
endinterface

interface mebf_out_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [31:0] address;
  logic [31:0] pixel_data;
  logic [1:0]  access_size;
  logic        last;

  modport source (output valid, write_valid, address, pixel_data, access_size, last,
                  input ready);
  modport sink   (input valid, write_valid, address, pixel_data, access_size, last,
                  output ready);
endinterface

### rtl/core/mebf_regs.sv
// APB configuration registers: frame base, screen size and depth.
// Depends on mebf_pkg.
module mebf_regs
  import mebf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_base    <= '0;
      cfg.screen_width  <= RST_SCREEN_WIDTH;
      cfg.screen_height <= RST_SCREEN_HEIGHT;
      cfg.depth_mode    <= DEPTH_32;
    end else if (wr_en) begin
      unique case (idx)
        REG_FRAME_BASE:    cfg.frame_base    <= pwdata;
        REG_SCREEN_WIDTH:  cfg.screen_width  <= pwdata[11:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= pwdata[11:0];
        REG_DEPTH_MODE:    cfg.depth_mode    <= depth_t'(pwdata[1:0]);
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_FRAME_BASE:    prdata = cfg.frame_base;
      REG_SCREEN_WIDTH:  prdata = {20'd0, cfg.screen_width};
      REG_SCREEN_HEIGHT: prdata = {20'd0, cfg.screen_height};
      REG_DEPTH_MODE:    prdata = {30'd0, cfg.depth_mode};
    endcase
  end

endmodule

### rtl/core/mebf_walk.sv
// Region walker: latches the region on a begin request, steps the column/row
// counters on each pixel request and registers the pixel position. Uses mebf_pkg.
module mebf_walk
  import mebf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mebf_in_if.sink    pix_in,
  input  logic       take,
  output logic       s1_valid,
  output walk_t      s1
);

  logic signed [11:0] region_left;
  logic signed [11:0] region_top;
  logic [11:0]        region_cols;
  logic [11:0]        region_rows;
  logic [31:0]        held_colour;
  logic               held_mode;
  logic [11:0]        column_count;
  logic [11:0]        row_count;

  logic        accept;
  logic        active;
  logic [11:0] col_inc;
  logic [11:0] row_inc;
  logic        row_end;
  walk_t       s1_next;

  // Stage 1 drains into the pixel stage, so it is free whenever that moves
  assign pix_in.ready = !s1_valid || take;
  assign accept       = pix_in.valid && pix_in.ready;

  assign active  = (region_cols != '0) && (region_rows != '0) &&
                   (row_count < region_rows) && (column_count < region_cols);
  assign col_inc = column_count + 12'd1;
  assign row_inc = row_count + 12'd1;
  assign row_end = (col_inc >= region_cols);

  // Position of the current pixel
  always_comb begin
    s1_next.x        = 14'(region_left) + $signed({2'b00, column_count});
    s1_next.y        = 14'(region_top) + $signed({2'b00, row_count});
    s1_next.colour   = held_colour;
    s1_next.glyph    = held_mode;
    s1_next.coverage = pix_in.coverage;
    s1_next.last     = (col_inc == region_cols) && (row_inc == region_rows);
  end

  // Latch region and advance counters
  always_ff @(posedge clk) begin
    if (rst) begin
      region_left  <= '0;
      region_top   <= '0;
      region_cols  <= '0;
      region_rows  <= '0;
      held_colour  <= '0;
      held_mode    <= 1'b0;
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (cmd_t'(pix_in.command) == CMD_BEGIN) begin
        region_left  <= pix_in.left;
        region_top   <= pix_in.top;
        region_cols  <= pix_in.region_width;
        region_rows  <= pix_in.region_height;
        held_colour  <= pix_in.colour;
        held_mode    <= pix_in.fill_mode;
        column_count <= '0;
        row_count    <= '0;
      end else if (active) begin
        if (row_end) begin
          column_count <= '0;
          row_count    <= row_inc;
        end else begin
          column_count <= col_inc;
        end
      end
    end
  end

  // Stage 1 register: hold a pixel until the pixel stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && cmd_t'(pix_in.command) == CMD_PIXEL && active) begin
      s1_valid <= 1'b1;
    end else if (take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

endmodule

### rtl/core/mebf_pixel.sv
// Pixel stage: clips, forms the framebuffer address and data, and holds the
// result in the output register. Uses mebf_pkg.
module mebf_pixel
  import mebf_pkg::*;
#(
  parameter int MAX_SCREEN_WIDTH  = 2048,
  parameter int MAX_SCREEN_HEIGHT = 2048
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       s1_valid,
  input  walk_t      s1,
  output logic       take,
  mebf_out_if.source pix_out
);

  localparam logic [12:0] MAX_W = 13'(MAX_SCREEN_WIDTH);
  localparam logic [12:0] MAX_H = 13'(MAX_SCREEN_HEIGHT);

  logic [12:0] sw;
  logic [12:0] sh;
  logic        visible;
  logic [14:0] pitch;
  logic [14:0] x_off;
  logic [27:0] row_off;
  logic [31:0] addr;
  logic [31:0] c;
  logic [31:0] data;

  assign take = !pix_out.valid || pix_out.ready;

  // Saturate the screen size and clip
  assign sw = ({1'b0, cfg.screen_width} > MAX_W) ? MAX_W : {1'b0, cfg.screen_width};
  assign sh = ({1'b0, cfg.screen_height} > MAX_H) ? MAX_H : {1'b0, cfg.screen_height};
  assign visible = !s1.x[13] && !s1.y[13] && (s1.x[12:0] < sw) && (s1.y[12:0] < sh) &&
                   (cfg.depth_mode != DEPTH_NONE);

  // Address: base + y * pitch + x * bytes per pixel
  assign pitch   = 15'(sw) << cfg.depth_mode;
  assign x_off   = 15'(s1.x[12:0]) << cfg.depth_mode;
  assign row_off = {15'd0, s1.y[12:0]} * {13'd0, pitch};
  assign addr    = cfg.frame_base + {4'd0, row_off} + {17'd0, x_off};

  // Pick glyph background on empty coverage and format for the depth
  assign c = (s1.glyph && s1.coverage == 8'd0) ? GLYPH_BACKGROUND : s1.colour;
  always_comb begin
    unique case (cfg.depth_mode)
      DEPTH_8:    data = {24'd0, c[7:0]};
      DEPTH_16:   data = {16'd0, to_rgb565(c)};
      DEPTH_32:   data = c;
      DEPTH_NONE: data = c;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (take) begin
      pix_out.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s1_valid) begin
      pix_out.write_valid <= visible;
      pix_out.address     <= visible ? addr : '0;
      pix_out.pixel_data  <= visible ? data : '0;
      pix_out.access_size <= visible ? 2'(cfg.depth_mode) : 2'd0;
      pix_out.last        <= s1.last;
    end
  end

endmodule

### rtl/core/mono_expand_blit_and_fill_unit.sv
// Rectangle fill and mono glyph expansion to framebuffer writes.
// Pipe: walker stage 1 register, then the pixel stage output register.
// Throughput: one request per cycle unless pix_out stalls; begin requests and
// pixels of an empty or finished region give no result. Rate set by that pipe.
// Reset (rst, synchronous): clears region, counters and pipeline valids and
// loads the registers with base 0, 640x480, 32 bpp.
module mono_expand_blit_and_fill_unit
  import mebf_pkg::*;
#(
  parameter int MAX_SCREEN_WIDTH  = 2048,
  parameter int MAX_SCREEN_HEIGHT = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  mebf_in_if.sink               pix_in,
  mebf_out_if.source            pix_out
);

  cfg_t  cfg;
  walk_t s1;
  logic  s1_valid;
  logic  take;

  mebf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mebf_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix_in),
    .take     (take),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  mebf_pixel #(
    .MAX_SCREEN_WIDTH  (MAX_SCREEN_WIDTH),
    .MAX_SCREEN_HEIGHT (MAX_SCREEN_HEIGHT)
  ) u_pixel (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1       (s1),
    .take     (take),
    .pix_out  (pix_out)
  );

endmodule

### rtl/core/mebf_checker.sv
// Port-level checks for the blit and fill unit, bound to the top level.
// Depends on mebf_pkg and the top level mono_expand_blit_and_fill_unit.
module mebf_checker
  import mebf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        write_valid,
  input logic [31:0] address,
  input logic [31:0] pixel_data,
  input logic [1:0]  access_size
);

  // No result is offered the cycle after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({write_valid, address, pixel_data, access_size}))
    else $error("stalled result changed");

  // A clipped pixel carries zero address, data and size
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_valid |-> address == '0 && pixel_data == '0 && access_size == 2'd0)
    else $error("clipped pixel with nonzero payload");

  // A write never uses the unsupported depth code
  assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid |-> access_size != 2'(DEPTH_NONE))
    else $error("write with unsupported depth");

  // Data fits the access size
  assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid && access_size != 2'(DEPTH_32) |-> pixel_data[31:16] == '0 &&
      (access_size != 2'(DEPTH_8) || pixel_data[15:8] == '0))
    else $error("pixel data wider than access");

endmodule

bind mono_expand_blit_and_fill_unit mebf_checker u_mebf_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (pix_out.valid),
  .out_ready   (pix_out.ready),
  .write_valid (pix_out.write_valid),
  .address     (pix_out.address),
  .pixel_data  (pix_out.pixel_data),
  .access_size (pix_out.access_size)
);
